[design/msa_pkg.sv]
package msa_pkg;

	localparam int MAX_SEATS = 64;
	localparam int SLOT_W    = 6;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 7;

	// The row can never be longer than the slot field can address.
	localparam int ROW_LIMIT_I = (MAX_SEATS < (1 << SLOT_W)) ? MAX_SEATS : (1 << SLOT_W);
	localparam logic [CFG_W-1:0] ROW_LIMIT = CFG_W'(ROW_LIMIT_I);

	localparam logic [0:0] KIND_SEAT  = 1'b0;
	localparam logic [0:0] KIND_LEAVE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] position;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] status;
	} result_t;

	// One free run to weigh against the best found so far.
	typedef struct packed {
		logic              left_valid;
		logic [SLOT_W-1:0] left;
		logic [CFG_W-1:0]  right;
		logic [CFG_W-1:0]  row_len;
		logic              found;
		logic [CFG_W-1:0]  best_dist;
	} gap_req_t;

	typedef struct packed {
		logic              take;
		logic [SLOT_W-1:0] pos;
		logic [CFG_W-1:0]  distance;
	} gap_rsp_t;

endpackage

[design/max_distance_slot_allocator_core.sv]
// Channel   Ports                     Handshake
// item      start, busy, item         taken when start is high and busy is low
// result    done, result              one cycle, marked by done, cannot be held off
// config    cfg_we, cfg_data          seat_count written when cfg_we is high
//
// A seat request walks the row one slot per cycle through a single gap
// evaluation unit in ST_SCAN, then ST_SEAT registers the slot and done.
// A leave request is checked in the cycle it is taken and shows its result on the next.
// Reset frees every slot and sets seat_count to 64. Busy stays high while a
// seat scan runs; a new item may be taken during the cycle done is shown.
module max_distance_slot_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  msa_pkg::item_t              item,
	output logic                        done,
	output msa_pkg::result_t            result,
	input  logic                        cfg_we,
	input  logic [msa_pkg::CFG_W-1:0]   cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_SEAT = 3'b100
	} state_t;

	localparam int ROW_W = (msa_pkg::ROW_LIMIT_I > 0) ? msa_pkg::ROW_LIMIT_I : 1;

	state_t                      state_q;
	logic [msa_pkg::CFG_W-1:0]   seat_count_q;
	logic [ROW_W-1:0]            occupied_q;
	logic [msa_pkg::CFG_W-1:0]   idx_q;
	logic                        left_valid_q;
	logic [msa_pkg::SLOT_W-1:0]  left_q;
	logic                        found_q;
	logic [msa_pkg::SLOT_W-1:0]  best_pos_q;
	logic [msa_pkg::CFG_W-1:0]   best_dist_q;
	logic                        done_q;
	msa_pkg::result_t            result_q;

	logic [msa_pkg::CFG_W-1:0]   row_len;
	logic                        accept;
	logic                        at_end;
	logic                        slot_taken;
	logic                        leave_ok;
	msa_pkg::gap_req_t           gap_req;
	msa_pkg::gap_rsp_t           gap_rsp;

	assign row_len = (seat_count_q > msa_pkg::ROW_LIMIT) ? msa_pkg::ROW_LIMIT : seat_count_q;
	assign accept  = start && !busy;
	assign at_end  = (idx_q == row_len);
	assign slot_taken = occupied_q[idx_q[msa_pkg::SLOT_W-1:0]];
	assign leave_ok = ({1'b0, item.position} < row_len) && occupied_q[item.position];

	assign gap_req.left_valid = left_valid_q;
	assign gap_req.left       = left_q;
	assign gap_req.right      = idx_q;
	assign gap_req.row_len    = row_len;
	assign gap_req.found      = found_q;
	assign gap_req.best_dist  = best_dist_q;

	msa_gap_unit u_gap (
		.req (gap_req),
		.rsp (gap_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_count_q <= msa_pkg::CFG_W'(64);
		end else if (cfg_we) begin
			seat_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			occupied_q   <= '0;
			done_q       <= 1'b0;
			idx_q        <= '0;
			left_valid_q <= 1'b0;
			found_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= accept && (item.kind == msa_pkg::KIND_LEAVE);
					if (accept) begin
						if (item.kind == msa_pkg::KIND_SEAT) begin
							idx_q        <= '0;
							left_valid_q <= 1'b0;
							found_q      <= 1'b0;
							state_q      <= ST_SCAN;
						end else begin
							result_q.slot <= item.position;
							if (leave_ok) begin
								occupied_q[item.position] <= 1'b0;
								result_q.status <= msa_pkg::STATUS_OK;
							end else begin
								result_q.status <= msa_pkg::STATUS_BAD_FREE;
							end
						end
					end
				end
				ST_SCAN: begin
					done_q <= 1'b0;
					// Each taken slot, and finally the row end, closes a free run.
					if (at_end || slot_taken) begin
						if (gap_rsp.take) begin
							found_q     <= 1'b1;
							best_pos_q  <= gap_rsp.pos;
							best_dist_q <= gap_rsp.distance;
						end
						left_valid_q <= 1'b1;
						left_q       <= idx_q[msa_pkg::SLOT_W-1:0];
					end
					if (at_end) begin
						state_q <= ST_SEAT;
					end else begin
						idx_q <= idx_q + msa_pkg::CFG_W'(1);
					end
				end
				ST_SEAT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (found_q) begin
						occupied_q[best_pos_q] <= 1'b1;
						result_q.slot   <= best_pos_q;
						result_q.status <= msa_pkg::STATUS_OK;
					end else begin
						result_q.slot   <= '0;
						result_q.status <= msa_pkg::STATUS_FULL;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[design/msa_gap_unit.sv]
module msa_gap_unit (
	input  msa_pkg::gap_req_t req,
	output msa_pkg::gap_rsp_t rsp
);

	logic [msa_pkg::CFG_W-1:0] left_ext;
	logic [msa_pkg::CFG_W-1:0] span;
	logic [msa_pkg::CFG_W-1:0] half;
	logic [msa_pkg::CFG_W-1:0] run_dist;
	logic [msa_pkg::SLOT_W-1:0] pos;
	logic empty_run;

	assign left_ext = {{(msa_pkg::CFG_W - msa_pkg::SLOT_W){1'b0}}, req.left};
	assign span     = req.right - left_ext;
	assign half     = span >> 1;

	always_comb begin
		empty_run = req.left_valid ? (span < msa_pkg::CFG_W'(2)) : (req.right == '0);
		priority if (!req.left_valid) begin
			// Open run at the row start: seat at slot 0.
			pos      = '0;
			run_dist = req.right;
		end else if (req.right == req.row_len) begin
			// Open run at the row end: seat at the last slot.
			run_dist = req.row_len - left_ext - msa_pkg::CFG_W'(1);
			pos      = msa_pkg::SLOT_W'(req.row_len - msa_pkg::CFG_W'(1));
		end else begin
			run_dist = half;
			pos      = req.left + msa_pkg::SLOT_W'(half);
		end
	end

	assign rsp.take     = !empty_run && (!req.found || run_dist > req.best_dist);
	assign rsp.pos      = pos;
	assign rsp.distance = run_dist;

endmodule

[tb/seat_result_checker.sv]
`timescale 1ns / 1ps

module seat_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  msa_pkg::item_t              item,
	input  logic                        done,
	input  msa_pkg::result_t            result,
	input  logic                        cfg_we,
	input  logic [msa_pkg::CFG_W-1:0]   cfg_data,
	output int                          mismatches,
	output int                          pending,
	output int                          checked,
	output int                          rejected,
	output logic [63:0]                 taken_map
);

	localparam int ROW_MAX = (msa_pkg::MAX_SEATS < 64) ? msa_pkg::MAX_SEATS : 64;

	typedef struct packed {
		logic                       found;
		logic [msa_pkg::SLOT_W-1:0] pos;
	} seat_choice_t;

	logic [msa_pkg::CFG_W-1:0] seat_limit;
	logic [63:0]               seated;
	msa_pkg::result_t          expected_results[$];
	int                        miss_count;
	int                        checked_count;
	int                        reject_count;

	function automatic int row_length(input logic [msa_pkg::CFG_W-1:0] limit);
		return (int'(limit) > ROW_MAX) ? ROW_MAX : int'(limit);
	endfunction

	// Each free run is bounded by taken slots or row ends; an end run puts the
	// seat at the row end, an inner run in its middle. Ties keep the first run.
	function automatic seat_choice_t best_free_slot(input logic [63:0] occ, input int n);
		seat_choice_t choice;
		int           left;
		int           cand;
		int           cand_dist;
		int           best_dist;
		int           i;
		choice    = '0;
		best_dist = 0;
		left      = -1;
		for (i = 0; i <= n; i++) begin
			if (i == n || occ[i]) begin
				if (i - left >= 2) begin
					if (left < 0) begin
						cand      = 0;
						cand_dist = i;
					end else if (i == n) begin
						cand      = n - 1;
						cand_dist = n - 1 - left;
					end else begin
						cand      = left + (i - left) / 2;
						cand_dist = (i - left) / 2;
					end
					if (!choice.found || cand_dist > best_dist) begin
						choice.found = 1'b1;
						choice.pos   = cand[msa_pkg::SLOT_W-1:0];
						best_dist    = cand_dist;
					end
				end
				left = i;
			end
		end
		return choice;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		msa_pkg::result_t want;
		seat_choice_t     choice;
		int               n;
		if (!arst_n) begin
			seat_limit    = 7'd64;
			seated        = '0;
			miss_count    = 0;
			checked_count = 0;
			reject_count  = 0;
			expected_results.delete();
		end else begin
			// The result beat is retired before a request taken on the same edge.
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: slot %0d status %0d",
						result.slot, result.status);
					miss_count++;
				end else begin
					want = expected_results.pop_front();
					checked_count++;
					if (result.slot !== want.slot) begin
						$error("slot mismatch: expected %0d, got %0d", want.slot, result.slot);
						miss_count++;
					end
					if (result.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.status, result.status);
						miss_count++;
					end
				end
			end
			if (start && !busy) begin
				n = row_length(seat_limit);
				if (item.kind == msa_pkg::KIND_SEAT) begin
					choice = best_free_slot(seated, n);
					if (choice.found) begin
						seated[choice.pos] = 1'b1;
						want.slot          = choice.pos;
						want.status        = msa_pkg::STATUS_OK;
					end else begin
						want.slot   = '0;
						want.status = msa_pkg::STATUS_FULL;
					end
				end else begin
					want.slot = item.position;
					if (int'(item.position) >= n || !seated[item.position]) begin
						want.status = msa_pkg::STATUS_BAD_FREE;
					end else begin
						seated[item.position] = 1'b0;
						want.status           = msa_pkg::STATUS_OK;
					end
				end
				if (want.status != msa_pkg::STATUS_OK)
					reject_count++;
				expected_results.push_back(want);
			end
			if (cfg_we)
				seat_limit = cfg_data;
		end
		mismatches <= miss_count;
		pending    <= expected_results.size();
		checked    <= checked_count;
		rejected   <= reject_count;
		taken_map  <= seated;
	end

endmodule

[tb/max_distance_slot_allocator_core_tb.sv]
`timescale 1ns / 1ps

module max_distance_slot_allocator_core_tb;

	localparam int ROW_MAX    = (msa_pkg::MAX_SEATS < 64) ? msa_pkg::MAX_SEATS : 64;
	localparam int STALL_LIMIT = 1000;
	localparam int MODE_ITEMS  = 650;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	msa_pkg::item_t            item;
	logic                      done;
	msa_pkg::result_t          result;
	logic                      cfg_we;
	logic [msa_pkg::CFG_W-1:0] cfg_data;

	int                        mismatches;
	int                        pending;
	int                        checked;
	int                        rejected;
	logic [63:0]               taken_map;

	int                        items_sent;
	int                        settings_used;
	int                        stall_cycles;
	logic [msa_pkg::CFG_W-1:0] seat_setting;

	max_distance_slot_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	seat_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.rejected   (rejected),
		.taken_map  (taken_map)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the rising edge that takes the beat.
	task automatic feed(input logic kind, input logic [msa_pkg::SLOT_W-1:0] pos);
		msa_pkg::item_t next;
		next.kind     = kind;
		next.position = pos;
		start <= 1'b1;
		item  <= next;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic request(input logic kind, input logic [msa_pkg::SLOT_W-1:0] pos);
		@(negedge clk);
		feed(kind, pos);
	endtask

	// The row is reprogrammed only once every outstanding result is back.
	task automatic write_seats(input logic [msa_pkg::CFG_W-1:0] value);
		@(negedge clk);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
		seat_setting = value;
		settings_used++;
	endtask

	function automatic logic [msa_pkg::CFG_W-1:0] pick_seat_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return msa_pkg::CFG_W'(0);
		if (r < 12)
			return msa_pkg::CFG_W'($urandom_range(65, 126));
		if (r < 16)
			return msa_pkg::CFG_W'(127);
		if (r < 28)
			return msa_pkg::CFG_W'(64);
		if (r < 38)
			return msa_pkg::CFG_W'(1);
		if (r < 80)
			return msa_pkg::CFG_W'($urandom_range(2, 16));
		return msa_pkg::CFG_W'($urandom_range(17, 63));
	endfunction

	task automatic random_request(input int idle_pct, input int seat_pct);
		int                        n;
		int                        taken;
		int                        pick;
		int                        i;
		logic                      kind;
		logic [msa_pkg::SLOT_W-1:0] pos;
		@(negedge clk);
		// Each cycle the sender stays quiet with the given chance.
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		n     = (int'(seat_setting) > ROW_MAX) ? ROW_MAX : int'(seat_setting);
		kind  = ($urandom_range(0, 99) < seat_pct) ? msa_pkg::KIND_SEAT : msa_pkg::KIND_LEAVE;
		pos   = msa_pkg::SLOT_W'($urandom_range(0, 63));
		taken = 0;
		for (i = 0; i < n; i++)
			taken += taken_map[i];
		// Most leaves name a slot that is really taken; the rest are noise.
		if (kind == msa_pkg::KIND_LEAVE && taken > 0 && $urandom_range(0, 99) < 85) begin
			pick = $urandom_range(0, taken - 1);
			for (i = 0; i < n; i++) begin
				if (taken_map[i]) begin
					if (pick == 0)
						pos = msa_pkg::SLOT_W'(i);
					pick--;
				end
			end
		end
		feed(kind, pos);
	endtask

	// Each phase fills the row with seat-heavy traffic, then drains it.
	task automatic run_mode(input int idle_pct, input int quota);
		int sent;
		int chunk;
		int fill_pct;
		int drain_pct;
		int j;
		sent = 0;
		while (sent < quota) begin
			write_seats(pick_seat_count());
			chunk     = $urandom_range(30, 110);
			if (chunk > quota - sent)
				chunk = quota - sent;
			fill_pct  = $urandom_range(65, 95);
			drain_pct = $urandom_range(15, 50);
			for (j = 0; j < chunk; j++)
				random_request(idle_pct, (j < chunk / 2) ? fill_pct : drain_pct);
			sent += chunk;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		item          = '0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		items_sent    = 0;
		settings_used = 0;
		seat_setting  = 7'd64;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty row, both ends, the middle, and leaves of taken and free slots.
		request(msa_pkg::KIND_SEAT, 6'd17);
		request(msa_pkg::KIND_SEAT, 6'd0);
		request(msa_pkg::KIND_SEAT, 6'd63);
		request(msa_pkg::KIND_LEAVE, 6'd31);
		request(msa_pkg::KIND_LEAVE, 6'd31);
		request(msa_pkg::KIND_LEAVE, 6'd63);
		request(msa_pkg::KIND_LEAVE, 6'd0);

		// A short row filled up, then leaves past its end.
		write_seats(7'd3);
		request(msa_pkg::KIND_SEAT, 6'd42);
		request(msa_pkg::KIND_SEAT, 6'd21);
		request(msa_pkg::KIND_SEAT, 6'd63);
		request(msa_pkg::KIND_SEAT, 6'd0);
		request(msa_pkg::KIND_LEAVE, 6'd3);
		request(msa_pkg::KIND_LEAVE, 6'd63);
		request(msa_pkg::KIND_LEAVE, 6'd1);
		request(msa_pkg::KIND_SEAT, 6'd5);

		// A row with no slots at all.
		write_seats(7'd0);
		request(msa_pkg::KIND_SEAT, 6'd0);
		request(msa_pkg::KIND_LEAVE, 6'd0);

		// A setting past the maximum saturates to the full row.
		write_seats(7'd127);
		request(msa_pkg::KIND_SEAT, 6'd9);

		write_seats(7'd1);
		request(msa_pkg::KIND_SEAT, 6'd0);
		request(msa_pkg::KIND_LEAVE, 6'd0);
		request(msa_pkg::KIND_SEAT, 6'd63);

		// Shrinking the row hides the taken end slot until it grows again.
		write_seats(7'd8);
		request(msa_pkg::KIND_SEAT, 6'd33);
		request(msa_pkg::KIND_LEAVE, 6'd63);
		write_seats(7'd64);
		request(msa_pkg::KIND_LEAVE, 6'd63);

		run_mode(12, MODE_ITEMS);
		run_mode(80, MODE_ITEMS);
		run_mode(0, MODE_ITEMS);

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (80)
			@(negedge clk);
		if (pending != 0)
			$error("%0d results never arrived", pending);

		$display("Sent %0d requests over %0d row-length settings in three pacing modes.",
			items_sent, settings_used);
		$display("Checked %0d results; %0d were row-full or bad-leave rejections.",
			checked, rejected);
		if (mismatches == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/msa_pkg.sv
design/msa_gap_unit.sv
design/max_distance_slot_allocator_core.sv
tb/seat_result_checker.sv
tb/max_distance_slot_allocator_core_tb.sv
